// File: hdl/lmax_pkg.sv
package lmax_pkg;

  // fixed register widths
  localparam int NUM_COLS_W = 7;
  localparam int NUM_ROWS_W = 13;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 13;

  // row counter runs up to num_rows + 2 while draining
  localparam int ROW_W = NUM_ROWS_W + 1;
  // at most num_cols + 1 results outstanding
  localparam int PEND_W = NUM_COLS_W + 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_COLS = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NUM_ROWS = 1'b1;

  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 7'd64;
  localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 13'd64;

  localparam int OUT_DATA_W = 8;

  // per-item control from the counter stage to the window stage
  typedef struct packed {
    logic first;    // column 0: window restarts behind the border
    logic ok_up;    // row two above lies inside the frame
    logic ok_mid;   // row above lies inside the frame
    logic ok_cur;   // current row holds a real sample
    logic emit;     // item gives a result
    logic eor;
    logic eof;
  } lmax_ctl_t;

endpackage

// File: hdl/lmax_line_store.sv
module lmax_line_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_r;
  logic [WIDTH-1:0] byp_r;
  logic             byp_hit_r;
  logic             rd_ok_r;
  logic [AW:0]      fill_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r  <= mem[rd_addr];
      byp_r <= wr_data;
    end
  end

  // a write to the same entry in the read cycle is not seen by the array read
  // entries are first written in ascending order from 0, so a fill mark tells
  // which ones hold data since reset; the others read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
      rd_ok_r   <= 1'b0;
      fill_r    <= '0;
    end else begin
      if (rd_en) begin
        byp_hit_r <= wr_en && (wr_addr == rd_addr);
        rd_ok_r   <= ({1'b0, rd_addr} < fill_r);
      end
      if (wr_en && ({1'b0, wr_addr} >= fill_r)) begin
        fill_r <= {1'b0, wr_addr} + (AW+1)'(1);
      end
    end
  end

  assign rd_data = byp_hit_r ? byp_r : (rd_ok_r ? rd_r : '0);

endmodule

// File: hdl/lmax_window.sv
module lmax_window #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  lmax_pkg::lmax_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] up_val,
  input  logic signed [SAMPLE_BITS-1:0] mid_val,
  input  logic signed [SAMPLE_BITS-1:0] cur_val,
  output logic                          is_peak
);
  import lmax_pkg::*;

  // left column and center column of the 3x3 window, row 0 on top
  logic signed [SAMPLE_BITS-1:0] left_r [3];
  logic signed [SAMPLE_BITS-1:0] cen_r  [3];
  logic [2:0]                    left_ok_r;
  logic [2:0]                    cen_ok_r;

  logic signed [SAMPLE_BITS-1:0] new_val [3];
  logic [2:0]                    new_ok;
  logic [2:0]                    right_ok;

  assign new_val[0] = up_val;
  assign new_val[1] = mid_val;
  assign new_val[2] = cur_val;
  assign new_ok     = {ctl.ok_cur, ctl.ok_mid, ctl.ok_up};
  // at column 0 the right neighbors lie beyond the previous row's end
  assign right_ok   = ctl.first ? 3'b000 : new_ok;

  always_comb begin
    is_peak = cen_ok_r[1];
    for (int k = 0; k < 3; k++) begin
      if (left_ok_r[k] && (left_r[k] >= cen_r[1])) begin
        is_peak = 1'b0;
      end
      if (right_ok[k] && (new_val[k] >= cen_r[1])) begin
        is_peak = 1'b0;
      end
      if ((k != 1) && cen_ok_r[k] && (cen_r[k] >= cen_r[1])) begin
        is_peak = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int k = 0; k < 3; k++) begin
        left_r[k] <= cen_r[k];
        cen_r[k]  <= new_val[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_ok_r <= 3'b000;
      cen_ok_r  <= 3'b000;
    end else if (shift) begin
      left_ok_r <= ctl.first ? 3'b000 : cen_ok_r;
      cen_ok_r  <= new_ok;
    end
  end

endmodule

// File: hdl/strict_3x3_local_max_detect.sv
// Streaming 3x3 strict local-maximum detector. Signed samples of a frame of
// num_rows x num_cols pixels enter in raster order on in_* (in_tuser = 0), and
// one flag per pixel leaves in raster order on out_*, set when the pixel is
// strictly greater than all eight neighbors (neighbors outside the frame never
// block a peak). A pixel's flag is due once the pixel below and to its right
// has been taken, i.e. num_cols + 1 items later; after the frame's last pixel,
// send drain ticks (in_tuser = 1) to push out the last num_cols + 1 flags;
// ticks with nothing due are absorbed without a result, and the block is ready
// for the next frame once the last flag has gone. num_cols is used clamped to
// 1..MAX_COLS and num_rows of 0 acts as 1; write them only while no item is
// inside the block.
// The block takes one item every clock while no flag waits on out_tready,
// limited by the single line store that holds the two previous rows and is
// read and written once per item; an item is registered in the window stage
// and its flag then in the result register. Line store entries not yet written
// since reset read as zero through a fill mark, so no clearing pass is needed.
module strict_3x3_local_max_detect #(
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // pixel_value
  input  logic [0:0]                             in_tuser,   // kind
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [lmax_pkg::OUT_DATA_W-1:0]        out_tdata,  // is_peak_flag
  output logic                                   out_tlast,  // end_of_row
  output logic [0:0]                             out_tuser,  // end_of_frame
  input  logic                                   cfg_wr_en,
  input  logic [lmax_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [lmax_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import lmax_pkg::*;

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = AW + 1;

  logic [NUM_COLS_W-1:0] num_cols_r;
  logic [NUM_ROWS_W-1:0] num_rows_r;
  logic [CW-1:0]         cols;
  logic [ROW_W-1:0]      rows;

  logic [AW-1:0]         col_r;
  logic [ROW_W-1:0]      row_r;
  logic [PEND_W-1:0]     pend_r;

  logic                  acc;
  logic                  drain;
  logic                  take;
  logic                  stuck;
  logic [AW-1:0]         c0;
  logic [ROW_W-1:0]      r0;
  logic [PEND_W-1:0]     pend_inc;
  logic [PEND_W-1:0]     pend_nxt;
  logic [AW-1:0]         col_nxt;
  logic [ROW_W-1:0]      row_nxt;
  lmax_ctl_t             ctl_nxt;
  logic [CW-1:0]         c1;

  logic                          b_valid_r;
  lmax_ctl_t                     b_ctl_r;
  logic [AW-1:0]                 b_addr_r;
  logic signed [SAMPLE_BITS-1:0] b_pix_r;
  logic                          b_fire;

  logic [2*SAMPLE_BITS-1:0]      ls_rd;
  logic signed [SAMPLE_BITS-1:0] up_val;
  logic signed [SAMPLE_BITS-1:0] mid_val;
  logic                          is_peak;

  logic out_valid_r;
  logic out_peak_r;
  logic out_eor_r;
  logic out_eof_r;

  // ---------------- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cols_r <= NUM_COLS_RST;
      num_rows_r <= NUM_ROWS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_NUM_COLS: num_cols_r <= cfg_wdata[NUM_COLS_W-1:0];
        CFG_NUM_ROWS: num_rows_r <= cfg_wdata[NUM_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_cols_r == '0) begin
      cols = CW'(1);
    end else if (32'(num_cols_r) > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(num_cols_r);
    end
    rows = (num_rows_r == '0) ? ROW_W'(1) : ROW_W'(num_rows_r);
  end

  // ---------------- position counters and result bookkeeping
  assign acc   = in_tvalid && in_tready;
  assign drain = in_tuser[0];

  always_comb begin
    c0       = col_r;
    r0       = row_r;
    take     = 1'b0;
    stuck    = 1'b0;
    ctl_nxt  = '0;
    c1       = '0;
    col_nxt  = '0;
    row_nxt  = '0;
    if ({1'b0, col_r} >= cols) begin
      c0 = '0;
      r0 = row_r + ROW_W'(1);
    end
    if (!drain) begin
      take = r0 < rows;
    end else if ((pend_r != '0) && (r0 >= rows)) begin
      // drain ran past every due result
      if (r0 >= rows + ROW_W'(2)) begin
        stuck = 1'b1;
      end else begin
        take = 1'b1;
      end
    end
    pend_inc       = drain ? pend_r : pend_r + PEND_W'(1);
    ctl_nxt.first  = (c0 == '0);
    ctl_nxt.ok_up  = (r0 >= ROW_W'(2)) && ((r0 - ROW_W'(2)) < rows);
    ctl_nxt.ok_mid = (r0 >= ROW_W'(1)) && ((r0 - ROW_W'(1)) < rows);
    ctl_nxt.ok_cur = !drain;
    ctl_nxt.emit   = (ctl_nxt.first ? ctl_nxt.ok_up : ctl_nxt.ok_mid) && (pend_inc != '0);
    ctl_nxt.eor    = ctl_nxt.first;
    ctl_nxt.eof    = ctl_nxt.first && (r0 == rows + ROW_W'(1));
    pend_nxt       = ctl_nxt.emit ? pend_inc - PEND_W'(1) : pend_inc;
    c1             = {1'b0, c0} + CW'(1);
    if (c1 >= cols) begin
      col_nxt = '0;
      row_nxt = r0 + ROW_W'(1);
    end else begin
      col_nxt = c1[AW-1:0];
      row_nxt = r0;
    end
    // last result of the drain: back to the frame start
    if (drain && (pend_nxt == '0)) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else if (acc && stuck) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else if (acc && take) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // ---------------- window stage
  assign b_fire    = b_valid_r && (!b_ctl_r.emit || !out_valid_r || out_tready);
  assign in_tready = !b_valid_r || b_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (acc && take) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && take) begin
      b_ctl_r  <= ctl_nxt;
      b_addr_r <= c0;
      b_pix_r  <= drain ? '0 : signed'(in_tdata[SAMPLE_BITS-1:0]);
    end
  end

  // each entry holds {row two above, row above} for its column
  lmax_line_store #(
    .DEPTH (MAX_COLS),
    .AW    (AW),
    .WIDTH (2*SAMPLE_BITS)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc && take),
    .rd_addr (c0),
    .wr_en   (b_fire),
    .wr_addr (b_addr_r),
    .wr_data ({mid_val, b_pix_r}),
    .rd_data (ls_rd)
  );

  assign up_val  = signed'(ls_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign mid_val = signed'(ls_rd[SAMPLE_BITS-1:0]);

  lmax_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift   (b_fire),
    .ctl     (b_ctl_r),
    .up_val  (up_val),
    .mid_val (mid_val),
    .cur_val (b_pix_r),
    .is_peak (is_peak)
  );

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && b_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_ctl_r.emit) begin
      out_peak_r <= is_peak;
      out_eor_r  <= b_ctl_r.eor;
      out_eof_r  <= b_ctl_r.eof;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_peak_r};
  assign out_tlast  = out_eor_r;
  assign out_tuser  = out_eof_r;

`ifndef SYNTHESIS
  // a stalled window stage keeps its item
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_fire) |=> (b_valid_r && $stable(b_ctl_r) && $stable(b_addr_r)))
    else $error("window stage lost a stalled item");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && b_ctl_r.emit && out_valid_r) |-> out_tready)
    else $error("result overwritten before transfer");

  // the drain tick that gives the last result rewinds the counters
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && drain && take && (pend_nxt == '0)) |=>
      ((row_r == '0) && (col_r == '0) && (pend_r == '0)))
    else $error("counters not rewound at end of drain");
`endif

endmodule

// File: bench/strict_3x3_local_max_detect_test.sv
module strict_3x3_local_max_detect_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lmax_pkg::*;

  localparam int MAX_COLS    = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;

  typedef enum bit {KIND_PIXEL = 1'b0, KIND_DRAIN = 1'b1} kind_e;
  typedef enum int {MIX_FULL, MIX_TIES, MIX_EDGE} mix_e;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] data;
  } feed_t;

  typedef struct {
    bit peak;
    bit eor;
    bit eof;
  } flag_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;   // pixel_value
  logic [0:0]            in_tuser   = '0;   // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // is_peak_flag
  logic                  out_tlast;         // end_of_row
  logic [0:0]            out_tuser;         // end_of_frame
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  strict_3x3_local_max_detect #(
    .MAX_COLS   (MAX_COLS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #2ns clk = ~clk;

  // detector model state
  logic [NUM_COLS_W-1:0] cols_reg = NUM_COLS_RST;
  logic [NUM_ROWS_W-1:0] rows_reg = NUM_ROWS_RST;
  sample_t               up_row  [MAX_COLS];
  sample_t               mid_row [MAX_COLS];
  sample_t               win     [9];   // column * 3 + row, top row first
  bit                    win_ok  [9];
  int                    row_pos, col_pos, owed;

  feed_t pixel_feed [$];
  flag_t due_flags  [$];
  flag_t head_flag;
  feed_t next_item;

  int  n_sent, n_taken, n_err, n_flags, n_peaks, n_px, n_ticks, n_frames;
  int  in_gap, out_hold, quiet_cycles;
  bit  steady, hung;

  function automatic int cols_eff();
    if (cols_reg == 0) return 1;
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic int rows_eff();
    return (rows_reg == 0) ? 1 : int'(rows_reg);
  endfunction

  function automatic int pick_gap();
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t pick_px(input mix_e mix);
    int k;
    k = $urandom_range(0, 3);
    case (mix)
      MIX_FULL: return sample_t'($urandom);
      MIX_TIES: return sample_t'(int'($urandom_range(0, 4)) - 2);
      default: begin
        if (k == 0) return sample_t'(-32768);
        if (k == 1) return sample_t'(32767);
        if (k == 2) return sample_t'(32766);
        return sample_t'($urandom);
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    n_err++;
    if (n_err <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  // one accepted item: moves the window and queues the flag it makes due
  task automatic predict_peak_flag(input bit drain, input sample_t px);
    int      rows, cols, r, c, crow, ccol, k;
    sample_t col_v [3];
    bit      col_ok [3];
    bit      emit, peak;
    flag_t   f;
    rows = rows_eff();
    cols = cols_eff();
    r = row_pos;
    c = col_pos;
    emit = 1'b0;
    crow = 0;
    ccol = 0;
    // width shrunk under a running row: go on at the next row
    if (c >= cols) begin
      c = 0;
      r++;
    end
    if (!drain) begin
      if (r >= rows) return;
      owed++;
      n_px++;
    end else begin
      if (owed == 0 || r < rows) return;
      // drain ran past every due flag: give up what is owed
      if (r >= rows + 2) begin
        owed = 0;
        row_pos = 0;
        col_pos = 0;
        return;
      end
      px = '0;
    end
    col_v[0] = up_row[c];
    col_v[1] = mid_row[c];
    col_v[2] = px;
    col_ok[0] = (r >= 2) && (r - 2 < rows);
    col_ok[1] = (r >= 1) && (r - 1 < rows);
    col_ok[2] = !drain;
    up_row[c] = mid_row[c];
    mid_row[c] = px;
    // column 0 shifts in a border column and closes the previous row
    for (k = 0; k < 6; k++) begin
      win[k] = win[k+3];
      win_ok[k] = win_ok[k+3];
    end
    for (k = 0; k < 3; k++) begin
      win[6+k] = (c == 0) ? sample_t'(0) : col_v[k];
      win_ok[6+k] = (c != 0) && col_ok[k];
    end
    if (c == 0) begin
      if (r >= 2 && r - 2 < rows) begin
        emit = 1'b1;
        crow = r - 2;
        ccol = cols - 1;
      end
    end else if (r >= 1 && r - 1 < rows) begin
      emit = 1'b1;
      crow = r - 1;
      ccol = c - 1;
    end
    if (emit && owed > 0) begin
      peak = win_ok[4];
      for (k = 0; k < 9; k++)
        if (k != 4 && win_ok[k] && win[k] >= win[4]) peak = 1'b0;
      owed--;
      f.peak = peak;
      f.eor = (ccol == cols - 1);
      f.eof = f.eor && (crow == rows - 1);
      due_flags.push_back(f);
    end
    if (c == 0) begin
      for (k = 0; k < 6; k++) begin
        win[k] = '0;
        win_ok[k] = 1'b0;
      end
      for (k = 0; k < 3; k++) begin
        win[6+k] = col_v[k];
        win_ok[6+k] = col_ok[k];
      end
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
    end
    if (drain && owed == 0) begin
      r = 0;
      c = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_peak_flag(in_tuser[0] == KIND_DRAIN, sample_t'(in_tdata));
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (pixel_feed.size() != 0) begin
          next_item = pixel_feed.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= next_item.kind;
          in_tdata <= next_item.data;
          in_gap <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_flags++;
        if (due_flags.size() == 0) begin
          flag_mismatch($sformatf("flag %0d with nothing due (data %h last %b user %b)",
                                  n_flags, out_tdata, out_tlast, out_tuser));
        end else begin
          head_flag = due_flags.pop_front();
          n_peaks += head_flag.peak;
          if (out_tdata !== OUT_DATA_W'(head_flag.peak))
            flag_mismatch($sformatf("flag %0d: is_peak_flag data %h, want %0d",
                                    n_flags, out_tdata, head_flag.peak));
          if (out_tlast !== head_flag.eor)
            flag_mismatch($sformatf("flag %0d: end_of_row %b, want %0d",
                                    n_flags, out_tlast, head_flag.eor));
          if (out_tuser[0] !== head_flag.eof)
            flag_mismatch($sformatf("flag %0d: end_of_frame %b, want %0d",
                                    n_flags, out_tuser, head_flag.eof));
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_tready <= 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_hold <= pick_gap();
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
        quiet_cycles <= 0;
      else if (quiet_cycles >= QUIET_LIMIT)
        hung <= 1'b1;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (hung);
    $display("no transfer for %0d cycles, %0d flags still due", QUIET_LIMIT,
             due_flags.size());
    $display("** strict_3x3_local_max_detect: FAILED **");
    $finish;
  end

  task automatic push_px(input sample_t v);
    feed_t it;
    it.kind = KIND_PIXEL;
    it.data = v;
    pixel_feed.push_back(it);
    n_sent++;
  endtask

  task automatic push_tick();
    feed_t it;
    it.kind = KIND_DRAIN;
    it.data = 16'($urandom);
    pixel_feed.push_back(it);
    n_sent++;
    n_ticks++;
  endtask

  // every item taken, every flag out, then time for the pipeline to settle
  task automatic wait_idle();
    do @(negedge clk); while (n_taken != n_sent || due_flags.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_NUM_COLS) cols_reg = val[NUM_COLS_W-1:0];
    else rows_reg = val[NUM_ROWS_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_shape(input int c, input int r);
    logic [CFG_DATA_W-1:0] v;
    wait_idle();
    // bits above the column field lie outside that register
    v = CFG_DATA_W'($urandom);
    v[NUM_COLS_W-1:0] = c[NUM_COLS_W-1:0];
    write_reg(CFG_NUM_COLS, v);
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(r));
  endtask

  // drain after the last pixel, optionally with a stray pixel mixed in
  task automatic close_frame(input bit stray);
    int k, at;
    at = stray ? $urandom_range(0, cols_eff()) : -1;
    for (k = 0; k <= cols_eff(); k++) begin
      if (k == at) push_px(pick_px(MIX_FULL));
      push_tick();
    end
    wait_idle();
    while (owed != 0) begin
      push_tick();
      wait_idle();
    end
    n_frames++;
  endtask

  task automatic run_frame(input mix_e mix, input bit pause_mid, input bit noise,
                           input bit stray);
    int total, k, cut;
    total = cols_eff() * rows_eff();
    cut = $urandom_range(1, total);
    for (k = 0; k < total; k++) begin
      if (k == cut && pause_mid) wait_idle();
      if (k == cut && noise) push_tick();
      push_px(pick_px(mix));
    end
    close_frame(stray);
  endtask

  initial begin
    int k, p, c, r;
    for (k = 0; k < MAX_COLS; k++) begin
      up_row[k] = '0;
      mid_row[k] = '0;
    end
    for (k = 0; k < 9; k++) begin
      win[k] = '0;
      win_ok[k] = 1'b0;
    end
    row_pos = 0;
    col_pos = 0;
    owed = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // drain tick with nothing owed
    push_tick();

    // 3x3 frame: one strict peak in the middle, extremes and ties around it
    set_shape(3, 3);
    push_px(sample_t'(-32768));
    push_px(sample_t'(5));
    push_px(sample_t'(-32768));
    push_px(sample_t'(5));
    push_tick();
    push_px(sample_t'(32767));
    push_px(sample_t'(5));
    push_px(sample_t'(-1));
    push_px(sample_t'(0));
    push_px(sample_t'(32766));
    close_frame(1'b1);

    // one-row frame with an equal pair: the first drain tick has nothing due
    set_shape(2, 1);
    push_px(sample_t'(7));
    push_px(sample_t'(7));
    close_frame(1'b0);

    // clamped shapes and the widest row
    set_shape(127, 2);
    run_frame(MIX_FULL, 1'b0, 1'b0, 1'b0);
    set_shape(0, 0);
    run_frame(MIX_EDGE, 1'b0, 1'b0, 1'b1);
    set_shape(64, 3);
    run_frame(MIX_TIES, 1'b1, 1'b1, 1'b1);

    // width shrinks part way through the first row
    set_shape(8, 4);
    repeat (5) push_px(pick_px(MIX_TIES));
    wait_idle();
    write_reg(CFG_NUM_COLS, CFG_DATA_W'(3));
    repeat (9) push_px(pick_px(MIX_TIES));
    close_frame(1'b0);

    // height shrinks after the frame so the drain is stuck past the end
    set_shape(4, 6);
    repeat (24) push_px(pick_px(MIX_FULL));
    wait_idle();
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(2));
    push_tick();
    set_shape(1, 8191);
    repeat (30) push_px(pick_px(MIX_EDGE));
    wait_idle();
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(0));
    push_tick();

    while (n_sent < 1500) begin
      p = $urandom_range(0, 99);
      if (p < 80) c = $urandom_range(1, 10);
      else if (p < 95) c = $urandom_range(11, 64);
      else if (p < 97) c = 0;
      else c = $urandom_range(65, 127);
      if (c > 16) r = $urandom_range(0, 3);
      else if ($urandom_range(0, 99) < 85) r = $urandom_range(0, 6);
      else r = $urandom_range(7, 16);
      set_shape(c, r);
      steady = ($urandom_range(0, 4) == 0);
      run_frame(mix_e'($urandom_range(0, 2)), $urandom_range(0, 7) == 0,
                $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
      steady = 1'b0;
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (due_flags.size() != 0)
      flag_mismatch($sformatf("%0d flags never came out", due_flags.size()));
    $display("covered %0d frames: %0d pixels, %0d drain ticks, %0d flags checked (%0d peaks)",
             n_frames, n_px, n_ticks, n_flags, n_peaks);
    $display("widths 1..64 with clamping, one-row frames, mid-row shrink, stuck drain");
    if (n_err == 0)
      $display("** strict_3x3_local_max_detect: PASSED **");
    else
      $display("** strict_3x3_local_max_detect: FAILED **");
    $finish;
  end

endmodule
